// ----- rtl/lss_pkg.sv -----
// Lottery slot scheduler package: request/result payload types, table control struct,
// status, command, outcome and sequencer state codes.
// No dependencies.
package lss_pkg;

    localparam int RESULT_TOTAL_W = 18;
    localparam logic [31:0] TOTAL_MAX = 32'd262143;

    localparam logic [1:0] CMD_CREATE   = 2'd0;
    localparam logic [1:0] CMD_FINISH   = 2'd1;
    localparam logic [1:0] CMD_SCHEDULE = 2'd2;

    localparam logic [1:0] OUT_UPDATE     = 2'd0;
    localparam logic [1:0] OUT_REFILL     = 2'd1;
    localparam logic [1:0] OUT_NO_TICKETS = 2'd2;
    localparam logic [1:0] OUT_LOTTERY    = 2'd3;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_READY    = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_FINISHED = 2'd3
    } slot_state_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CMD,
        SEQ_SUM,
        SEQ_DECIDE,
        SEQ_MOD,
        SEQ_WALK,
        SEQ_RESP
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  slot;
        logic [15:0] tickets;
        logic [31:0] random_value;
        logic        more_to_create;
    } lss_req_t;

    typedef struct packed {
        logic [2:0]                next_slot;
        logic [1:0]                outcome;
        logic [RESULT_TOTAL_W-1:0] ticket_total;
    } lss_rsp_t;

    // table operations issued by the sequencer, at most one per cycle
    typedef struct packed {
        logic create;
        logic finish;
        logic retire;
        logic run;
    } lss_tbl_cmd_t;

endpackage

// ----- rtl/lss_alu.sv -----
// Shared add/subtract unit used for the ticket sum, the modulo and the prefix walk.
// Depends on nothing.
module lss_alu #(
    parameter int WIDTH = 21
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] y,
    output logic             borrow
);

    logic [WIDTH:0] full;

    always_comb
    begin
        if (sub)
        begin
            full = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            full = {1'b0, a} + {1'b0, b};
        end
    end

    assign y      = full[WIDTH-1:0];
    assign borrow = full[WIDTH];

endmodule

// ----- rtl/lss_table.sv -----
// Slot table: per-slot status and tickets, running slot register.
// Depends on lss_pkg.
module lss_table #(
    parameter int WORKER_SLOTS = 4,
    parameter int TICKET_W     = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lss_pkg::lss_tbl_cmd_t              cmd,
    input  logic [$clog2(WORKER_SLOTS+1)-1:0]  run_idx,
    input  logic [$clog2(WORKER_SLOTS+1)-1:0]  create_slot,
    input  logic [TICKET_W-1:0]                create_tickets,
    input  logic [$clog2(WORKER_SLOTS+1)-1:0]  rd_idx,
    output logic [TICKET_W-1:0]                rd_tickets,
    output logic                               empty_found,
    output logic [$clog2(WORKER_SLOTS+1)-1:0]  running
);

    localparam int SW = $clog2(WORKER_SLOTS + 1);

    lss_pkg::slot_state_t status_reg  [0:WORKER_SLOTS];
    lss_pkg::slot_state_t status_next [0:WORKER_SLOTS];
    logic [TICKET_W-1:0]  tickets_reg  [0:WORKER_SLOTS];
    logic [TICKET_W-1:0]  tickets_next [0:WORKER_SLOTS];
    logic [SW-1:0]        running_reg;
    logic [SW-1:0]        running_next;

    always_comb
    begin
        running_next = running_reg;
        for (int i = 0; i <= WORKER_SLOTS; i++)
        begin
            status_next[i]  = status_reg[i];
            tickets_next[i] = tickets_reg[i];
            if (cmd.create && i != 0 && SW'(i) == create_slot)
            begin
                status_next[i]  = lss_pkg::ST_READY;
                tickets_next[i] = create_tickets;
            end
            if (cmd.finish && i != 0 && SW'(i) == running_reg)
            begin
                status_next[i] = lss_pkg::ST_FINISHED;
            end
            if (cmd.retire)
            begin
                // finished slots are freed whether running or not
                if (status_reg[i] == lss_pkg::ST_FINISHED)
                begin
                    status_next[i]  = lss_pkg::ST_EMPTY;
                    tickets_next[i] = '0;
                end
                else if (SW'(i) == running_reg)
                begin
                    status_next[i] = lss_pkg::ST_READY;
                end
            end
            if (cmd.run && SW'(i) == run_idx)
            begin
                status_next[i] = lss_pkg::ST_RUNNING;
            end
        end
        if (cmd.run)
        begin
            running_next = run_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= WORKER_SLOTS; i++)
            begin
                status_reg[i]  <= (i == 0) ? lss_pkg::ST_RUNNING : lss_pkg::ST_EMPTY;
                tickets_reg[i] <= '0;
            end
            running_reg <= '0;
        end
        else
        begin
            for (int i = 0; i <= WORKER_SLOTS; i++)
            begin
                status_reg[i]  <= status_next[i];
                tickets_reg[i] <= tickets_next[i];
            end
            running_reg <= running_next;
        end
    end

    always_comb
    begin
        empty_found = 1'b0;
        for (int i = 1; i <= WORKER_SLOTS; i++)
        begin
            if (status_reg[i] == lss_pkg::ST_EMPTY)
            begin
                empty_found = 1'b1;
            end
        end
    end

    assign rd_tickets = tickets_reg[rd_idx];
    assign running    = running_reg;

endmodule

// ----- rtl/lss_seq.sv -----
// Sequencer: decodes a request, drives the table and the shared adder through
// ticket sum, restoring modulo and prefix walk, then presents the result. Depends on lss_pkg.
module lss_seq #(
    parameter int WORKER_SLOTS = 4,
    parameter int TICKET_W     = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  lss_pkg::lss_req_t                            request,
    output logic                                         busy,
    output logic                                         done,
    output lss_pkg::lss_rsp_t                            result,
    output lss_pkg::lss_tbl_cmd_t                        tbl_cmd,
    output logic [$clog2(WORKER_SLOTS+1)-1:0]            run_idx,
    output logic [$clog2(WORKER_SLOTS+1)-1:0]            create_slot,
    output logic [TICKET_W-1:0]                          create_tickets,
    output logic [$clog2(WORKER_SLOTS+1)-1:0]            rd_idx,
    input  logic [TICKET_W-1:0]                          rd_tickets,
    input  logic                                         empty_found,
    input  logic [$clog2(WORKER_SLOTS+1)-1:0]            running,
    output logic [TICKET_W+$clog2(WORKER_SLOTS):0]       alu_a,
    output logic [TICKET_W+$clog2(WORKER_SLOTS):0]       alu_b,
    output logic                                         alu_sub,
    input  logic [TICKET_W+$clog2(WORKER_SLOTS):0]       alu_y,
    input  logic                                         alu_borrow
);

    localparam int SW       = $clog2(WORKER_SLOTS + 1);
    localparam int SUM_BITS = TICKET_W + $clog2(WORKER_SLOTS);
    localparam int AW       = SUM_BITS + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(WORKER_SLOTS);

    lss_pkg::seq_state_t state_reg, state_next;
    lss_pkg::lss_req_t   req_reg, req_next;
    logic [SW-1:0]       idx_reg, idx_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic [SUM_BITS-1:0] rem_reg, rem_next;
    logic [31:0]         rnd_reg, rnd_next;
    logic [1:0]          outcome_reg, outcome_next;
    logic [AW-1:0]       shifted;
    logic                create_ok;
    logic [31:0]         sum_wide;

    assign create_ok = (req_reg.slot != 3'd0) && (32'(req_reg.slot) <= WORKER_SLOTS);
    assign shifted   = {rem_reg, rnd_reg[31]};

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        rem_next     = rem_reg;
        rnd_next     = rnd_reg;
        outcome_next = outcome_reg;
        tbl_cmd      = '0;
        run_idx      = '0;
        alu_a        = '0;
        alu_b        = '0;
        alu_sub      = 1'b0;
        done         = 1'b0;

        case (state_reg)
            lss_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = lss_pkg::SEQ_CMD;
                end
            end
            lss_pkg::SEQ_CMD:
            begin
                outcome_next = lss_pkg::OUT_UPDATE;
                sum_next     = '0;
                idx_next     = SW'(1);
                state_next   = lss_pkg::SEQ_RESP;
                case (req_reg.command)
                    lss_pkg::CMD_CREATE:   tbl_cmd.create = create_ok;
                    lss_pkg::CMD_FINISH:   tbl_cmd.finish = 1'b1;
                    lss_pkg::CMD_SCHEDULE:
                    begin
                        tbl_cmd.retire = 1'b1;
                        state_next     = lss_pkg::SEQ_SUM;
                    end
                    default: ;
                endcase
            end
            lss_pkg::SEQ_SUM:
            begin
                alu_a    = AW'(sum_reg);
                alu_b    = AW'(rd_tickets);
                sum_next = alu_y[SUM_BITS-1:0];
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = lss_pkg::SEQ_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end
            lss_pkg::SEQ_DECIDE:
            begin
                if (req_reg.more_to_create && empty_found)
                begin
                    tbl_cmd.run  = 1'b1;
                    outcome_next = lss_pkg::OUT_REFILL;
                    state_next   = lss_pkg::SEQ_RESP;
                end
                else if (sum_reg == '0)
                begin
                    tbl_cmd.run  = 1'b1;
                    outcome_next = lss_pkg::OUT_NO_TICKETS;
                    state_next   = lss_pkg::SEQ_RESP;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = '1;
                    rnd_next   = req_reg.random_value;
                    state_next = lss_pkg::SEQ_MOD;
                end
            end
            lss_pkg::SEQ_MOD:
            begin
                // restoring remainder, one dividend bit per cycle
                alu_a    = shifted;
                alu_b    = AW'(sum_reg);
                alu_sub  = 1'b1;
                rem_next = alu_borrow ? shifted[SUM_BITS-1:0] : alu_y[SUM_BITS-1:0];
                rnd_next = {rnd_reg[30:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    idx_next   = SW'(1);
                    state_next = lss_pkg::SEQ_WALK;
                end
            end
            lss_pkg::SEQ_WALK:
            begin
                alu_a   = AW'(rem_reg);
                alu_b   = AW'(rd_tickets);
                alu_sub = 1'b1;
                if (alu_borrow)
                begin
                    tbl_cmd.run  = 1'b1;
                    run_idx      = idx_reg;
                    outcome_next = lss_pkg::OUT_LOTTERY;
                    state_next   = lss_pkg::SEQ_RESP;
                end
                else
                begin
                    rem_next = alu_y[SUM_BITS-1:0];
                    if (idx_reg == LAST_SLOT)
                    begin
                        tbl_cmd.run  = 1'b1;
                        outcome_next = lss_pkg::OUT_LOTTERY;
                        state_next   = lss_pkg::SEQ_RESP;
                    end
                    else
                    begin
                        idx_next = idx_reg + SW'(1);
                    end
                end
            end
            lss_pkg::SEQ_RESP:
            begin
                done       = 1'b1;
                state_next = lss_pkg::SEQ_IDLE;
            end
            default:
            begin
                state_next = lss_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lss_pkg::SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        sum_reg     <= sum_next;
        rem_reg     <= rem_next;
        rnd_reg     <= rnd_next;
        outcome_reg <= outcome_next;
    end

    assign busy           = (state_reg != lss_pkg::SEQ_IDLE);
    assign create_slot    = SW'(req_reg.slot);
    assign create_tickets = TICKET_W'(req_reg.tickets);
    assign rd_idx         = idx_reg;

    assign sum_wide = 32'(sum_reg);

    always_comb
    begin
        result.next_slot = 3'(running);
        result.outcome   = outcome_reg;
        if (sum_wide > lss_pkg::TOTAL_MAX)
        begin
            result.ticket_total = '1;
        end
        else
        begin
            result.ticket_total = sum_wide[lss_pkg::RESULT_TOTAL_W-1:0];
        end
    end

endmodule

// ----- rtl/lottery_slot_scheduler_top.sv -----
// Lottery slot scheduler top level: slot table, shared adder and sequencer.
// Depends on lss_pkg, lss_table, lss_alu, lss_seq.
//
//  channel   | ports                  | handshake
//  ----------+------------------------+-----------------------------------
//  request   | start, busy, request   | taken when start=1 and busy=0
//  result    | done, result           | one-cycle strobe, no back-pressure
//
// Create, finish and unknown commands: the sequencer goes from SEQ_CMD to SEQ_RESP,
// where done is high. Schedule: one adder pass per slot sums the tickets, then a
// refill or no-ticket choice in SEQ_DECIDE goes to SEQ_RESP; a lottery adds 32
// restoring-remainder steps on the same adder and a prefix walk of up to
// WORKER_SLOTS steps before SEQ_RESP.
// busy drops the cycle after done; the receiver cannot stall.
// Reset puts main running and clears all worker slots; no sweep is needed.
module lottery_slot_scheduler_top #(
    parameter int WORKER_SLOTS = 4,
    parameter int TICKET_BITS  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lss_pkg::lss_req_t request,
    output logic              busy,
    output logic              done,
    output lss_pkg::lss_rsp_t result
);

    localparam int TICKET_W = (TICKET_BITS < 16) ? TICKET_BITS : 16;
    localparam int SW       = $clog2(WORKER_SLOTS + 1);
    localparam int AW       = TICKET_W + $clog2(WORKER_SLOTS) + 1;

    lss_pkg::lss_tbl_cmd_t tbl_cmd;
    logic [SW-1:0]         run_idx;
    logic [SW-1:0]         create_slot;
    logic [TICKET_W-1:0]   create_tickets;
    logic [SW-1:0]         rd_idx;
    logic [TICKET_W-1:0]   rd_tickets;
    logic                  empty_found;
    logic [SW-1:0]         running;
    logic [AW-1:0]         alu_a;
    logic [AW-1:0]         alu_b;
    logic                  alu_sub;
    logic [AW-1:0]         alu_y;
    logic                  alu_borrow;

    lss_table #(
        .WORKER_SLOTS (WORKER_SLOTS),
        .TICKET_W     (TICKET_W)
    ) u_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (tbl_cmd),
        .run_idx        (run_idx),
        .create_slot    (create_slot),
        .create_tickets (create_tickets),
        .rd_idx         (rd_idx),
        .rd_tickets     (rd_tickets),
        .empty_found    (empty_found),
        .running        (running)
    );

    lss_alu #(
        .WIDTH (AW)
    ) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .y      (alu_y),
        .borrow (alu_borrow)
    );

    lss_seq #(
        .WORKER_SLOTS (WORKER_SLOTS),
        .TICKET_W     (TICKET_W)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .request        (request),
        .busy           (busy),
        .done           (done),
        .result         (result),
        .tbl_cmd        (tbl_cmd),
        .run_idx        (run_idx),
        .create_slot    (create_slot),
        .create_tickets (create_tickets),
        .rd_idx         (rd_idx),
        .rd_tickets     (rd_tickets),
        .empty_found    (empty_found),
        .running        (running),
        .alu_a          (alu_a),
        .alu_b          (alu_b),
        .alu_sub        (alu_sub),
        .alu_y          (alu_y),
        .alu_borrow     (alu_borrow)
    );

endmodule

// ----- tb/lottery_slot_scheduler_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for lottery_slot_scheduler_top: directed table, then random requests
// checked against a local model of the slot table and lottery draw.
// Depends on lss_pkg and lottery_slot_scheduler_top.
module lottery_slot_scheduler_top_tb;

    localparam int         WORKERS       = 4;
    localparam int         TICKET_BITS   = 16;
    localparam logic [1:0] CMD_UNDEFINED = 2'd3;
    localparam int         RANDOM_ITEMS  = 412;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         TAIL_CYCLES   = 64;

    typedef struct {
        lss_pkg::lss_req_t req;
        bit                typed;
        lss_pkg::lss_rsp_t rsp;
    } directed_row_t;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    lss_pkg::lss_req_t request = '0;
    logic              busy;
    logic              done;
    lss_pkg::lss_rsp_t result;

    // model of the slot table
    lss_pkg::slot_state_t tbl_status  [0:WORKERS];
    logic [15:0]          tbl_tickets [0:WORKERS];
    int unsigned          tbl_running;

    lss_pkg::lss_rsp_t expected_results[$];
    directed_row_t     directed_tab[$];
    lss_pkg::lss_rsp_t want_rsp;
    int                idle_pct;
    int                fail_count;
    int                stall_cycles;
    int                idle_plan[4] = '{0, 68, 0, 24};

    lottery_slot_scheduler_top #(
        .WORKER_SLOTS (WORKERS),
        .TICKET_BITS  (TICKET_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic lss_pkg::lss_req_t mk_req(logic [1:0] cmd, logic [2:0] slot,
                                                 logic [15:0] tk, logic [31:0] rv,
                                                 logic more);
        lss_pkg::lss_req_t r;
        r.command        = cmd;
        r.slot           = slot;
        r.tickets        = tk;
        r.random_value   = rv;
        r.more_to_create = more;
        return r;
    endfunction

    function automatic lss_pkg::lss_rsp_t mk_rsp(logic [2:0] next, logic [1:0] outc,
                                                 logic [17:0] total);
        lss_pkg::lss_rsp_t r;
        r.next_slot    = next;
        r.outcome      = outc;
        r.ticket_total = total;
        return r;
    endfunction

    task automatic add_row(lss_pkg::lss_req_t r, bit typed = 1'b0,
                           lss_pkg::lss_rsp_t rsp = '0);
        directed_row_t row;
        row.req   = r;
        row.typed = typed;
        row.rsp   = rsp;
        directed_tab.push_back(row);
    endtask

    function automatic void clear_slot(int unsigned s);
        tbl_status[s]  = lss_pkg::ST_EMPTY;
        tbl_tickets[s] = '0;
    endfunction

    // applies one request to the table model and returns the expected response: next slot, outcome and total
    function automatic lss_pkg::lss_rsp_t compute_next_slot(lss_pkg::lss_req_t r);
        lss_pkg::lss_rsp_t rsp;
        logic [31:0]       total;
        logic [31:0]       draw;
        int unsigned       win;
        bit                empty_found;
        rsp         = '0;
        total       = '0;
        win         = 0;
        empty_found = 1'b0;
        case (r.command)
            lss_pkg::CMD_CREATE:
            begin
                if (r.slot >= 1 && r.slot <= WORKERS)
                begin
                    tbl_status[r.slot]  = lss_pkg::ST_READY;
                    tbl_tickets[r.slot] = r.tickets;
                end
            end
            lss_pkg::CMD_FINISH:
            begin
                if (tbl_running != 0)
                    tbl_status[tbl_running] = lss_pkg::ST_FINISHED;
            end
            lss_pkg::CMD_SCHEDULE:
            begin
                if (tbl_status[tbl_running] == lss_pkg::ST_FINISHED)
                    clear_slot(tbl_running);
                else
                    tbl_status[tbl_running] = lss_pkg::ST_READY;
                for (int i = 1; i <= WORKERS; i++)
                    if (tbl_status[i] == lss_pkg::ST_FINISHED)
                        clear_slot(i);
                for (int i = 1; i <= WORKERS; i++)
                begin
                    total += tbl_tickets[i];
                    if (tbl_status[i] == lss_pkg::ST_EMPTY)
                        empty_found = 1'b1;
                end
                if (r.more_to_create && empty_found)
                begin
                    win         = 0;
                    rsp.outcome = lss_pkg::OUT_REFILL;
                end
                else if (total == 0)
                begin
                    win         = 0;
                    rsp.outcome = lss_pkg::OUT_NO_TICKETS;
                end
                else
                begin
                    draw = r.random_value % total;
                    for (int i = 1; i <= WORKERS; i++)
                    begin
                        if (win == 0)
                        begin
                            if (draw < tbl_tickets[i])
                                win = i;
                            else
                                draw -= tbl_tickets[i];
                        end
                    end
                    rsp.outcome = lss_pkg::OUT_LOTTERY;
                end
                tbl_running             = win;
                tbl_status[tbl_running] = lss_pkg::ST_RUNNING;
            end
            default: ;
        endcase
        rsp.next_slot    = tbl_running[2:0];
        rsp.ticket_total = (total > lss_pkg::TOTAL_MAX) ? 18'(lss_pkg::TOTAL_MAX) : total[17:0];
        return rsp;
    endfunction

    function automatic lss_pkg::lss_req_t random_request();
        lss_pkg::lss_req_t r;
        int                pick;
        int                flavor;
        pick             = $urandom_range(99);
        flavor           = $urandom_range(9);
        r.random_value   = $urandom();
        r.more_to_create = ($urandom_range(9) < 4);
        r.slot           = 3'($urandom_range(WORKERS, 1));
        r.tickets        = 16'($urandom());
        if (flavor == 0)
            r.tickets = '0;
        else if (flavor == 1)
            r.tickets = 16'hFFFF;
        else if (flavor == 2)
            r.tickets = 16'($urandom_range(8, 1));
        if (pick < 35)
        begin
            r.command = lss_pkg::CMD_CREATE;
            // now and then a slot outside the worker range
            if ($urandom_range(9) == 0)
                r.slot = 3'($urandom_range(7));
        end
        else if (pick < 55)
        begin
            r.command = lss_pkg::CMD_FINISH;
            r.slot    = 3'($urandom_range(7));
        end
        else if (pick < 95)
        begin
            r.command = lss_pkg::CMD_SCHEDULE;
            r.slot    = 3'($urandom_range(7));
        end
        else
        begin
            r.command = CMD_UNDEFINED;
            r.slot    = 3'($urandom_range(7));
        end
        return r;
    endfunction

    // holds start until the request is taken, then records what must come back
    task automatic issue_request(lss_pkg::lss_req_t r, bit typed,
                                 lss_pkg::lss_rsp_t typed_rsp);
        lss_pkg::lss_rsp_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = compute_next_slot(r);
        expected_results.push_back(typed ? typed_rsp : predicted);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending: next_slot=%0d outcome=%0d total=%0d",
                       result.next_slot, result.outcome, result.ticket_total);
                fail_count++;
            end
            else
            begin
                want_rsp = expected_results.pop_front();
                if (result.next_slot !== want_rsp.next_slot)
                begin
                    $error("next_slot: expected %0d, got %0d",
                           want_rsp.next_slot, result.next_slot);
                    fail_count++;
                end
                if (result.outcome !== want_rsp.outcome)
                begin
                    $error("outcome: expected %0d, got %0d", want_rsp.outcome, result.outcome);
                    fail_count++;
                end
                if (result.ticket_total !== want_rsp.ticket_total)
                begin
                    $error("ticket_total: expected %0d, got %0d",
                           want_rsp.ticket_total, result.ticket_total);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
            $display("** lottery_slot_scheduler_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        fail_count   = 0;
        stall_cycles = 0;
        idle_pct     = 0;
        for (int i = 0; i <= WORKERS; i++)
        begin
            tbl_status[i]  = lss_pkg::ST_EMPTY;
            tbl_tickets[i] = '0;
        end
        tbl_status[0] = lss_pkg::ST_RUNNING;
        tbl_running   = 0;

        // from reset: nothing live, odd commands and bad slots change nothing
        add_row(mk_req(lss_pkg::CMD_SCHEDULE, 3'd0, 16'd0, 32'd0, 1'b0), 1'b1,
                mk_rsp(3'd0, lss_pkg::OUT_NO_TICKETS, 18'd0));
        add_row(mk_req(lss_pkg::CMD_FINISH, 3'd0, 16'd0, 32'd0, 1'b0), 1'b1,
                mk_rsp(3'd0, lss_pkg::OUT_UPDATE, 18'd0));
        add_row(mk_req(CMD_UNDEFINED, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1), 1'b1,
                mk_rsp(3'd0, lss_pkg::OUT_UPDATE, 18'd0));
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd0, 16'hFFFF, 32'd0, 1'b0), 1'b1,
                mk_rsp(3'd0, lss_pkg::OUT_UPDATE, 18'd0));
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd5, 16'hFFFF, 32'd0, 1'b0), 1'b1,
                mk_rsp(3'd0, lss_pkg::OUT_UPDATE, 18'd0));
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd7, 16'hFFFF, 32'd0, 1'b0), 1'b1,
                mk_rsp(3'd0, lss_pkg::OUT_UPDATE, 18'd0));
        add_row(mk_req(lss_pkg::CMD_SCHEDULE, 3'd0, 16'd0, 32'd0, 1'b1), 1'b1,
                mk_rsp(3'd0, lss_pkg::OUT_REFILL, 18'd0));
        // fill every worker, one with zero tickets
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd1, 16'hFFFF, 32'd0, 1'b0), 1'b1,
                mk_rsp(3'd0, lss_pkg::OUT_UPDATE, 18'd0));
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd2, 16'd0, 32'd0, 1'b0), 1'b1,
                mk_rsp(3'd0, lss_pkg::OUT_UPDATE, 18'd0));
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd3, 16'd1, 32'd0, 1'b0), 1'b1,
                mk_rsp(3'd0, lss_pkg::OUT_UPDATE, 18'd0));
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd4, 16'hFFFF, 32'd0, 1'b0), 1'b1,
                mk_rsp(3'd0, lss_pkg::OUT_UPDATE, 18'd0));
        add_row(mk_req(lss_pkg::CMD_SCHEDULE, 3'd0, 16'd0, 32'd0, 1'b1), 1'b1,
                mk_rsp(3'd1, lss_pkg::OUT_LOTTERY, 18'd131071));
        add_row(mk_req(lss_pkg::CMD_SCHEDULE, 3'd0, 16'd0, 32'hFFFF_FFFF, 1'b0));
        add_row(mk_req(lss_pkg::CMD_FINISH, 3'd0, 16'd0, 32'd0, 1'b0));
        add_row(mk_req(lss_pkg::CMD_SCHEDULE, 3'd0, 16'd0, 32'h1234_5678, 1'b1));
        // all slots at full weight: largest total
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd1, 16'hFFFF, 32'd0, 1'b0));
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd2, 16'hFFFF, 32'd0, 1'b0));
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd3, 16'hFFFF, 32'd0, 1'b0));
        add_row(mk_req(lss_pkg::CMD_SCHEDULE, 3'd0, 16'd0, 32'h8000_0000, 1'b0));
        // overwrite every slot, the running one too, with zero tickets
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd1, 16'd0, 32'd0, 1'b0));
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd2, 16'd0, 32'd0, 1'b0));
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd3, 16'd0, 32'd0, 1'b0));
        add_row(mk_req(lss_pkg::CMD_CREATE, 3'd4, 16'd0, 32'd0, 1'b0));
        add_row(mk_req(lss_pkg::CMD_SCHEDULE, 3'd0, 16'd0, 32'hFFFF_FFFF, 1'b1));
        add_row(mk_req(lss_pkg::CMD_FINISH, 3'd0, 16'd0, 32'd0, 1'b0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tab[i])
            issue_request(directed_tab[i].req, directed_tab[i].typed, directed_tab[i].rsp);

        // each entry sets idle_pct for one random phase; a receiver stall has no effect on this interface
        foreach (idle_plan[p])
        begin
            idle_pct = idle_plan[p];
            repeat (RANDOM_ITEMS)
                issue_request(random_request(), 1'b0, '0);
        end

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("** lottery_slot_scheduler_top: PASSED **");
        else
            $display("** lottery_slot_scheduler_top: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lss_pkg.sv
rtl/lss_alu.sv
rtl/lss_table.sv
rtl/lss_seq.sv
rtl/lottery_slot_scheduler_top.sv
tb/lottery_slot_scheduler_top_tb.sv
